// File: rtl/rhlp_pkg.sv
// ----------------------------------------------------------------------------
// Reply header line parser package
// Item types, verdict codes, byte classes and character codes.
// ----------------------------------------------------------------------------
package rhlp_pkg;

  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharO     = 8'h4F;
  localparam logic [7:0] CharK     = 8'h4B;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [3:0] HexDigits = 4'd8;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_REFUSED   = 3'd1,
    VERDICT_MALFORMED = 3'd2,
    VERDICT_TOO_LONG  = 3'd3,
    VERDICT_HUNG_UP   = 3'd4
  } verdict_e;

  typedef enum logic [3:0] {
    CLS_HANGUP,
    CLS_CR,
    CLS_LF,
    CLS_ZERO,
    CLS_DIGIT,
    CLS_HEXALPHA,
    CLS_N,
    CLS_O,
    CLS_K,
    CLS_SPACE,
    CLS_OTHER
  } cls_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [63:0] reply_length;
    logic [31:0] reply_checksum;
  } out_item_t;

  typedef struct packed {
    cls_kind_e  kind;
    logic [3:0] nibble;
  } cls_t;

endpackage

// File: rtl/rhlp_fifo.sv
// ----------------------------------------------------------------------------
// Reply header line parser queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rhlp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("queue empty after push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");

endmodule

// File: rtl/rhlp_front.sv
// ----------------------------------------------------------------------------
// Reply header line parser front end
// Classifies each incoming item and drops carriage returns.
// ----------------------------------------------------------------------------
module rhlp_front
  import rhlp_pkg::*;
(
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  input  logic     mid_full_i,
  output logic     mid_push_o,
  output cls_t     cls_o
);

  logic [7:0] ch;

  assign ch     = in_item_i.rx_byte;
  assign full_o = mid_full_i;

  always_comb begin
    cls_o.nibble = ch[3:0];
    if (in_item_i.action) begin
      cls_o.kind = CLS_HANGUP;
    end else if (ch == CharCr) begin
      cls_o.kind = CLS_CR;
    end else if (ch == CharLf) begin
      cls_o.kind = CLS_LF;
    end else if (ch == CharNul) begin
      cls_o.kind = CLS_ZERO;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      cls_o.kind = CLS_DIGIT;
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      cls_o.kind   = CLS_HEXALPHA;
      cls_o.nibble = ch[3:0] + 4'd9;
    end else if (ch == CharN) begin
      cls_o.kind = CLS_N;
    end else if (ch == CharO) begin
      cls_o.kind = CLS_O;
    end else if (ch == CharK) begin
      cls_o.kind = CLS_K;
    end else if (ch == CharSpace) begin
      cls_o.kind = CLS_SPACE;
    end else begin
      cls_o.kind = CLS_OTHER;
    end
  end

  // drop carriage returns
  assign mid_push_o = push_i && !mid_full_i && (cls_o.kind != CLS_CR);

endmodule

// File: rtl/rhlp_back.sv
// ----------------------------------------------------------------------------
// Reply header line parser back end
// Runs the header parse over classified items and issues verdicts.
// ----------------------------------------------------------------------------
module rhlp_back
  import rhlp_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 160
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_t      cls_i,
  input  logic      mid_empty_i,
  output logic      mid_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam int unsigned PosW = $clog2(LINE_LIMIT);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_GOT_N,
    PH_GOT_O,
    PH_GOT_OK,
    PH_LENGTH,
    PH_REFUSED,
    PH_HEX
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [63:0] len_q, len_d;
  logic        seen_q, seen_d;
  logic [31:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        mal_q, mal_d;
  logic        ended_q, ended_d;
  logic        go, restart;
  logic [67:0] len_next;

  assign go        = !mid_empty_i && !res_full_i;
  assign mid_pop_o = go;
  assign len_next  = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + {64'd0, cls_i.nibble};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    len_d      = len_q;
    seen_d     = seen_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    mal_d      = mal_q;
    ended_d    = ended_q;
    restart    = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{verdict: VERDICT_OK, reply_length: 64'd0, reply_checksum: 32'd0};
    if (go) begin
      case (cls_i.kind)
        CLS_HANGUP: begin
          res_push_o    = 1'b1;
          res_o.verdict = VERDICT_HUNG_UP;
          restart       = 1'b1;
        end
        CLS_LF: begin
          res_push_o = 1'b1;
          restart    = 1'b1;
          if (phase_q == PH_REFUSED) begin
            res_o.verdict = VERDICT_REFUSED;
          end else if (!mal_q && phase_q == PH_HEX && cnt_q == HexDigits) begin
            res_o.verdict        = VERDICT_OK;
            res_o.reply_length   = len_q;
            res_o.reply_checksum = crc_q;
          end else begin
            res_o.verdict = VERDICT_MALFORMED;
          end
        end
        default: begin
          if (pos_q >= PosW'(LINE_LIMIT - 1)) begin
            res_push_o    = 1'b1;
            res_o.verdict = VERDICT_TOO_LONG;
            restart       = 1'b1;
          end else begin
            pos_d = pos_q + 1'b1;
            if (cls_i.kind == CLS_ZERO) begin
              ended_d = 1'b1;
            end else if (!ended_q && !mal_q) begin
              case (phase_q)
                PH_FIRST: begin
                  if (cls_i.kind == CLS_N) phase_d = PH_GOT_N;
                  else if (cls_i.kind == CLS_O) phase_d = PH_GOT_O;
                  else mal_d = 1'b1;
                end
                PH_GOT_N: begin
                  if (cls_i.kind == CLS_O) phase_d = PH_REFUSED;
                  else mal_d = 1'b1;
                end
                PH_GOT_O: begin
                  if (cls_i.kind == CLS_K) phase_d = PH_GOT_OK;
                  else mal_d = 1'b1;
                end
                PH_GOT_OK: begin
                  if (cls_i.kind == CLS_SPACE) phase_d = PH_LENGTH;
                  else mal_d = 1'b1;
                end
                PH_LENGTH: begin
                  if (cls_i.kind == CLS_DIGIT) begin
                    if (|len_next[67:64]) begin
                      mal_d = 1'b1;
                    end else begin
                      len_d  = len_next[63:0];
                      seen_d = 1'b1;
                    end
                  end else if (cls_i.kind == CLS_SPACE && seen_q) begin
                    phase_d = PH_HEX;
                  end else begin
                    mal_d = 1'b1;
                  end
                end
                PH_HEX: begin
                  if ((cls_i.kind == CLS_DIGIT || cls_i.kind == CLS_HEXALPHA)
                      && cnt_q < HexDigits) begin
                    crc_d = {crc_q[27:0], cls_i.nibble};
                    cnt_d = cnt_q + 1'b1;
                  end else begin
                    mal_d = 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      endcase
      if (restart) begin
        phase_d = PH_FIRST;
        pos_d   = '0;
        len_d   = '0;
        seen_d  = 1'b0;
        crc_d   = '0;
        cnt_d   = '0;
        mal_d   = 1'b0;
        ended_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      pos_q   <= '0;
      len_q   <= '0;
      seen_q  <= 1'b0;
      crc_q   <= '0;
      cnt_q   <= '0;
      mal_q   <= 1'b0;
      ended_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      mal_q   <= mal_d;
      ended_q <= ended_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEX) |-> (cnt_q == '0 && crc_q == '0))
    else $error("checksum taken outside hex field");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (len_q == '0))
    else $error("length nonzero without a digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.verdict != VERDICT_TOO_LONG) |=>
      (pos_q == '0 && phase_q == PH_FIRST))
    else $error("no restart after verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(LINE_LIMIT - 1))
    else $error("line position beyond limit");

endmodule

// File: rtl/reply_header_line_parser_top.sv
// ----------------------------------------------------------------------------
// Reply header line parser
// Recognises one reply header line per verdict from a byte stream.
// Each result passes the middle queue and then the result queue to its ports.
// Throughput: one item per cycle while neither queue is full; each item other
// than a carriage return, which is dropped on entry, updates the parse state.
// Reset clears both queues and the parse state to the line start.
// ----------------------------------------------------------------------------
module reply_header_line_parser_top
  import rhlp_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 160
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic      mid_push, mid_full, mid_empty, mid_pop;
  cls_t      cls_in, cls_out;
  logic      res_push, res_full;
  out_item_t res_item;

  rhlp_front u_front (
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .cls_o      (cls_in)
  );

  rhlp_fifo #(
    .Width ($bits(cls_t)),
    .Depth (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (cls_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (cls_out),
    .empty_o (mid_empty)
  );

  rhlp_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  rhlp_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule
